### src/hdc_pkg.sv
// Shared types and constants for the message header delta encoder.
package hdc_pkg;

    localparam int FIELDS = 6;

    typedef enum logic [3:0] {
        CODE_ZERO   = 4'd0,
        CODE_ONE    = 4'd1,
        CODE_SAME   = 4'd2,
        CODE_SHL    = 4'd3,
        CODE_SHR    = 4'd4,
        CODE_ADD8   = 4'd5,
        CODE_DEL8   = 4'd6,
        CODE_ADDU8  = 4'd7,
        CODE_DELU8  = 4'd8,
        CODE_ADD16  = 4'd9,
        CODE_DEL16  = 4'd10,
        CODE_ADDU16 = 4'd11,
        CODE_DELU16 = 4'd12,
        CODE_SET    = 4'd13
    } code_t;

    localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;
    localparam logic [31:0] MASK_HI24  = 32'hffff_ff00;
    localparam logic [31:0] MASK_LO24  = 32'h00ff_ffff;
    localparam logic [31:0] MASK_HI16  = 32'hffff_0000;
    localparam logic [31:0] MASK_LO16  = 32'h0000_ffff;

    // Result of one lane: chosen code, data right-aligned, and data byte count.
    typedef struct packed {
        code_t       code;
        logic [31:0] data;
        logic [2:0]  nbytes;
    } lane_res_t;

endpackage

### src/hdc_lane.sv
// One field lane: picks the delta code of a field against its stored value.
module hdc_lane (
    input  logic [31:0]       cur,
    input  logic [31:0]       prv,
    output hdc_pkg::lane_res_t res
);
    import hdc_pkg::*;

    logic [31:0] up;
    logic [31:0] dn;
    logic [31:0] shl;
    logic [31:0] shr;

    assign up  = cur - prv;
    assign dn  = prv - cur;
    assign shl = {prv[30:0], 1'b0};
    assign shr = {prv[31], prv[31:1]};

    always_comb
    begin
        res.code   = CODE_SET;
        res.data   = cur;
        res.nbytes = 3'd4;
        if (cur == '0)
        begin
            res.code = CODE_ZERO; res.data = '0; res.nbytes = 3'd0;
        end
        else if (cur == ALL_ONES)
        begin
            res.code = CODE_ONE; res.data = '0; res.nbytes = 3'd0;
        end
        else if (cur == prv)
        begin
            res.code = CODE_SAME; res.data = '0; res.nbytes = 3'd0;
        end
        else if (cur == shl)
        begin
            res.code = CODE_SHL; res.data = '0; res.nbytes = 3'd0;
        end
        else if (cur == shr)
        begin
            res.code = CODE_SHR; res.data = '0; res.nbytes = 3'd0;
        end
        else if ((up & MASK_HI24) == '0)
        begin
            res.code = CODE_ADD8; res.data = {24'd0, up[7:0]}; res.nbytes = 3'd1;
        end
        else if ((dn & MASK_HI24) == '0)
        begin
            res.code = CODE_DEL8; res.data = {24'd0, dn[7:0]}; res.nbytes = 3'd1;
        end
        else if ((up & MASK_LO24) == '0)
        begin
            res.code = CODE_ADDU8; res.data = {24'd0, up[31:24]}; res.nbytes = 3'd1;
        end
        else if ((dn & MASK_LO24) == '0)
        begin
            res.code = CODE_DELU8; res.data = {24'd0, dn[31:24]}; res.nbytes = 3'd1;
        end
        else if ((up & MASK_HI16) == '0)
        begin
            res.code = CODE_ADD16; res.data = {16'd0, up[15:0]}; res.nbytes = 3'd2;
        end
        else if ((dn & MASK_HI16) == '0)
        begin
            res.code = CODE_DEL16; res.data = {16'd0, dn[15:0]}; res.nbytes = 3'd2;
        end
        else if ((up & MASK_LO16) == '0)
        begin
            res.code = CODE_ADDU16; res.data = {16'd0, up[31:16]}; res.nbytes = 3'd2;
        end
        else if ((dn & MASK_LO16) == '0)
        begin
            res.code = CODE_DELU16; res.data = {16'd0, dn[31:16]}; res.nbytes = 3'd2;
        end
    end

endmodule

### src/hdc_serializer.sv
// Merging stage: walks the six lane results and sends the encoded header one byte a beat.
module hdc_serializer (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         load_valid,
    output logic                                         load_ready,
    input  hdc_pkg::lane_res_t [hdc_pkg::FIELDS-1:0]     res,
    output logic [7:0]                                   out_byte,
    output logic                                         last,
    output logic                                         out_valid,
    input  logic                                         out_ready
);
    import hdc_pkg::*;

    lane_res_t [FIELDS-1:0] held_reg;
    logic                   busy_reg;
    logic                   word_phase_reg;
    logic [1:0]             widx_reg;
    logic [2:0]             fld_reg;
    logic [1:0]             kb_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic                   last_reg;

    logic [FIELDS-1:0] has;
    logic [31:0]       codeword;
    logic [2:0]        from;
    logic              nf_found;
    logic [2:0]        nf;
    logic [2:0]        nf_m1;
    logic [31:0]       cur_data;
    logic [7:0]        byte_next;
    logic              emit;
    logic              done;
    logic              advance;
    logic              load;

    always_comb
    begin
        for (int f = 0; f < FIELDS; f++)
        begin
            has[f] = held_reg[f].nbytes != 3'd0;
        end
    end

    assign codeword = {8'h00, held_reg[5].code, held_reg[4].code, held_reg[3].code,
                       held_reg[2].code, held_reg[1].code, held_reg[0].code};

    // First field at or after 'from' that carries data bytes.
    assign from = word_phase_reg ? 3'd0 : fld_reg + 3'd1;

    always_comb
    begin
        nf_found = 1'b0;
        nf       = '0;
        for (int f = 0; f < FIELDS; f++)
        begin
            if (!nf_found && (3'(f) >= from) && has[f])
            begin
                nf_found = 1'b1;
                nf       = 3'(f);
            end
        end
    end

    assign nf_m1    = held_reg[nf].nbytes - 3'd1;
    assign cur_data = held_reg[fld_reg].data;

    always_comb
    begin
        if (word_phase_reg)
        begin
            case (widx_reg)
                2'd0:    byte_next = codeword[31:24];
                2'd1:    byte_next = codeword[23:16];
                2'd2:    byte_next = codeword[15:8];
                default: byte_next = codeword[7:0];
            endcase
        end
        else
        begin
            case (kb_reg)
                2'd0:    byte_next = cur_data[7:0];
                2'd1:    byte_next = cur_data[15:8];
                2'd2:    byte_next = cur_data[23:16];
                default: byte_next = cur_data[31:24];
            endcase
        end
    end

    assign emit    = busy_reg && (!out_valid_reg || out_ready);
    assign done    = word_phase_reg ? (widx_reg == 2'd3 && !nf_found)
                                    : (kb_reg == 2'd0 && !nf_found);
    assign advance = word_phase_reg ? (widx_reg == 2'd3 && nf_found)
                                    : (kb_reg == 2'd0 && nf_found);

    assign load_ready = !busy_reg || (emit && done);
    assign load       = load_valid && load_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            word_phase_reg <= 1'b1;
            widx_reg       <= '0;
            fld_reg        <= '0;
            kb_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg       <= 1'b1;
                word_phase_reg <= 1'b1;
                widx_reg       <= '0;
            end
            else if (emit && done)
            begin
                busy_reg <= 1'b0;
            end
            else if (emit)
            begin
                if (word_phase_reg && widx_reg != 2'd3)
                begin
                    widx_reg <= widx_reg + 2'd1;
                end
                else if (advance)
                begin
                    word_phase_reg <= 1'b0;
                    fld_reg        <= nf;
                    kb_reg         <= nf_m1[1:0];
                end
                else
                begin
                    kb_reg <= kb_reg - 2'd1;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= res;
        end
        if (emit)
        begin
            out_byte_reg <= byte_next;
            last_reg     <= done;
        end
    end

    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign out_valid = out_valid_reg;

    // While sending data bytes, the current field really carries data.
    a_field_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !word_phase_reg |-> (fld_reg < 3'(FIELDS)) && has[fld_reg])
        else $error("serializer sits on a field without data bytes");

    // The byte index never runs past the field's byte count.
    a_kb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !word_phase_reg |-> ({1'b0, kb_reg} < held_reg[fld_reg].nbytes))
        else $error("byte index outside the field's data");

    // Finishing a header always puts a last byte into the output register.
    a_done_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit && done |=> out_valid_reg && last_reg)
        else $error("end of header not marked last");

endmodule

### src/ipc_header_delta_encoder_unit.sv
// Top level of the message header delta encoder: field lanes, lane register and serializer.
//
//  Channel   Handshake               Payload                                  Beats
//  header    hdr_valid / hdr_ready   major minor ref_req ref_to response      one per header
//                                    payload_size
//  bytes     byte_valid / byte_ready out_byte last                            4 to 28 per header
//
// When a header is taken, six lanes compare every field with its stored value in that same
// cycle and the results are registered; the stored header is updated at the same edge.
// The serializer then sends the code word and data bytes one per cycle while byte_ready is held
// high, 4 to 28 bytes per header; the single byte output port sets the sustained rate.
// The next header is accepted while the current one is still being sent, so the byte stream
// has no gaps between headers. Reset clears the stored header to zero and empties the pipe.
// Stalls on the byte side fill the lane register and then hold off the header side.
module ipc_header_delta_encoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hdr_valid,
    output logic               hdr_ready,
    input  logic signed [31:0] major,
    input  logic signed [31:0] minor,
    input  logic signed [31:0] ref_req,
    input  logic signed [31:0] ref_to,
    input  logic signed [31:0] response,
    input  logic signed [31:0] payload_size,
    output logic               byte_valid,
    input  logic               byte_ready,
    output logic [7:0]         out_byte,
    output logic               last
);
    import hdc_pkg::*;

    // Stored header that the next one is compared against.
    logic [31:0]            prev_reg [FIELDS];
    logic [31:0]            cur      [FIELDS];
    lane_res_t [FIELDS-1:0] lane_res;
    // Lane register between the comparators and the serializer.
    lane_res_t [FIELDS-1:0] s1_res_reg;
    logic                   s1_valid_reg;
    logic                   ser_ready;
    logic                   accept;

    // A negative payload size counts as zero, both for coding and for storage.
    assign cur[0] = major;
    assign cur[1] = minor;
    assign cur[2] = ref_req;
    assign cur[3] = ref_to;
    assign cur[4] = response;
    assign cur[5] = payload_size[31] ? 32'd0 : payload_size;

    genvar g;
    generate
        for (g = 0; g < FIELDS; g++)
        begin : g_lane
            hdc_lane u_lane (
                .cur (cur[g]),
                .prv (prev_reg[g]),
                .res (lane_res[g])
            );
        end
    endgenerate

    assign hdr_ready = !s1_valid_reg || ser_ready;
    assign accept    = hdr_valid && hdr_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < FIELDS; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                for (int i = 0; i < FIELDS; i++)
                begin
                    prev_reg[i] <= cur[i];
                end
            end
            else if (ser_ready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= lane_res;
        end
    end

    hdc_serializer u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s1_valid_reg),
        .load_ready (ser_ready),
        .res        (s1_res_reg),
        .out_byte   (out_byte),
        .last       (last),
        .out_valid  (byte_valid),
        .out_ready  (byte_ready)
    );

endmodule
